@@ src/pbc_pkg.sv @@
// Package for the palette blend pixel compositor: item types, operation and
// blend-mode codes, and the per-channel blend helper functions.
// No dependencies.
`default_nettype none

package pbc_pkg;

  // Input item and result item
  typedef struct packed {
    logic        req_type;
    logic        src_indexed;
    logic [7:0]  src_index;
    logic [23:0] src_color;
    logic [23:0] base_color;
  } pbc_in_t;

  typedef struct packed {
    logic [23:0] out_color;
    logic        write_enable;
  } pbc_out_t;

  // Request type codes
  localparam logic REQ_PIXEL     = 1'b0;
  localparam logic REQ_PAL_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_OPERATION  = 2'd0;
  localparam logic [1:0] CFG_BLEND_MODE = 2'd1;
  localparam logic [1:0] CFG_FILL_COLOR = 2'd2;

  // Operation codes
  localparam logic [1:0] OP_COPY      = 2'd0;
  localparam logic [1:0] OP_TRANSP    = 2'd1;
  localparam logic [1:0] OP_COMPOSITE = 2'd2;
  localparam logic [1:0] OP_FILL      = 2'd3;

  // Blend mode codes (0..99 are alpha percent)
  localparam logic [6:0] MODE_OPAQUE = 7'd100;
  localparam logic [6:0] MODE_SUB    = 7'd101;
  localparam logic [6:0] MODE_ADD    = 7'd102;

  localparam logic [7:0] PCT_SCALE = 8'd100;
  localparam logic [7:0] CHAN_MAX  = 8'd255;

  // Divide by 100 as multiply by ceil(2^22/100), exact for products up to 255*155 as formed here
  localparam logic [31:0] DIV_RECIP = 32'd41944;
  localparam int          DIV_SHIFT = 22;

  localparam logic [6:0] MODE_RESET = MODE_OPAQUE;

  // Per-channel blend kind
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_ALPHA_DN,
    KIND_ALPHA_UP,
    KIND_SUB,
    KIND_ADD,
    KIND_SCALE,
    KIND_BRIGHT
  } pbc_kind_t;

  typedef struct packed {
    pbc_kind_t   kind;
    logic [15:0] prod;
    logic [7:0]  d;
    logic [7:0]  s;
  } pbc_chan_t;

  // First half of a channel blend: pick the rule and form the product
  function automatic pbc_chan_t chan_prep(input logic [6:0] mode,
                                          input logic [7:0] d,
                                          input logic [7:0] s);
    pbc_chan_t  c;
    logic [7:0] a;
    logic [7:0] b;
    c.d  = d;
    c.s  = s;
    a    = '0;
    b    = '0;
    if (mode == MODE_OPAQUE) begin
      c.kind = KIND_PASS;
    end else if (mode < MODE_OPAQUE) begin
      c.kind = (d < s) ? KIND_ALPHA_UP : KIND_ALPHA_DN;
      a      = (d < s) ? (s - d) : (d - s);
      b      = {1'b0, mode};
    end else if (mode == MODE_SUB) begin
      c.kind = KIND_SUB;
    end else if (mode == MODE_ADD) begin
      c.kind = KIND_ADD;
    end else if (s <= PCT_SCALE) begin
      c.kind = KIND_SCALE;
      a      = d;
      b      = s;
    end else begin
      c.kind = KIND_BRIGHT;
      a      = CHAN_MAX - d;
      b      = s - PCT_SCALE;
    end
    c.prod = {8'h00, a} * {8'h00, b};
    return c;
  endfunction

  // Second half: divide the product by 100 and combine with the base
  function automatic logic [7:0] chan_fin(input pbc_chan_t c);
    logic [31:0] full;
    logic [8:0]  q;
    logic [9:0]  sum;
    logic [7:0]  r;
    full = {16'h0000, c.prod} * DIV_RECIP;
    q    = full[DIV_SHIFT +: 9];
    sum  = '0;
    case (c.kind)
      KIND_PASS:     r = c.s;
      KIND_ALPHA_DN: r = c.d - q[7:0];
      KIND_ALPHA_UP: r = c.d + q[7:0];
      KIND_SUB:      r = (c.d >= c.s) ? (c.d - c.s) : 8'h00;
      KIND_ADD: begin
        sum = {2'b00, c.d} + {2'b00, c.s};
        r   = (sum > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum[7:0];
      end
      KIND_SCALE:    r = q[7:0];
      KIND_BRIGHT: begin
        sum = {2'b00, c.d} + {1'b0, q};
        r   = (sum > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum[7:0];
      end
      default:       r = c.s;
    endcase
    return r;
  endfunction

  // Palette port request
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [7:0]  index;
    logic [23:0] wdata;
  } pbc_pal_req_t;

  // Pixel leaving the lookup stage toward the blend stages
  typedef struct packed {
    logic [6:0]  mode;
    logic [23:0] dst;
    logic [23:0] src;
    logic        we;
  } pbc_s1_t;

endpackage

`default_nettype wire

@@ src/pbc_palette.sv @@
// Palette memory: synchronous single-port RAM with registered read,
// plus per-entry valid bits so unwritten entries read as zero. Uses pbc_pkg.
`default_nettype none

module pbc_palette #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pbc_pkg::pbc_pal_req_t req,
  output logic [23:0]              rdata
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0]                mem_r [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic [23:0]                rd_data_r;
  logic                       rd_ok_r;
  logic                       in_range;
  logic [AW-1:0]              addr;

  assign in_range = ({1'b0, req.index} < 9'(PALETTE_ENTRIES));
  assign addr     = req.index[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en && in_range) begin
      mem_r[addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (req.wr_en && in_range) begin
        vld_r[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok_r <= in_range && vld_r[addr];
      end
    end
  end

  assign rdata = rd_ok_r ? rd_data_r : 24'h000000;

endmodule

`default_nettype wire

@@ src/pbc_blend.sv @@
// Two-stage channel blend: product stage, then divide-by-100 and combine into
// the output register. Elastic valid/stall per stage. Uses pbc_pkg.
`default_nettype none

module pbc_blend (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s1_valid,
  input  wire pbc_pkg::pbc_s1_t s1,
  output logic                  s1_ready,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pbc_pkg::pbc_out_t     out_data
);

  pbc_pkg::pbc_chan_t prep [3];
  pbc_pkg::pbc_chan_t s2_chan_r [3];
  logic [7:0]         fin [3];
  logic               s2_v_r;
  logic               s2_v_nxt;
  logic               s2_we_r;
  logic               out_v_r;
  logic               out_v_nxt;
  pbc_pkg::pbc_out_t  out_data_r;
  logic               rdy2;
  logic               rdy3;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    assign prep[ch] = pbc_pkg::chan_prep(s1.mode, s1.dst[8*ch +: 8], s1.src[8*ch +: 8]);
    assign fin[ch]  = pbc_pkg::chan_fin(s2_chan_r[ch]);
  end

  // Advance a stage when the one after it is empty or moving
  assign rdy3      = !out_v_r || !out_stall;
  assign rdy2      = !s2_v_r || rdy3;
  assign s1_ready  = rdy2;
  assign s2_v_nxt  = (s1_valid && rdy2) || (s2_v_r && !rdy3);
  assign out_v_nxt = rdy3 ? s2_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && rdy2) begin
      for (int ch = 0; ch < 3; ch++) begin
        s2_chan_r[ch] <= prep[ch];
      end
      s2_we_r <= s1.we;
    end
    if (s2_v_r && rdy3) begin
      out_data_r.out_color    <= {fin[2], fin[1], fin[0]};
      out_data_r.write_enable <= s2_we_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ src/palette_blend_pixel_compositor.sv @@
// Palette blend pixel compositor, top level.
// Throughput: one item per cycle while in_stall is low; palette writes and pixels mix freely.
// A pixel's palette read and lookup-stage capture happen at its accept edge; it
// then passes the product stage and the divide/combine into the output register.
// Reset (synchronous, rst_n low): clears pipeline valids, config registers
// and every palette valid bit, so the palette reads as zero.
`default_nettype none

module palette_blend_pixel_compositor #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // pixel / palette-write items
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pbc_pkg::pbc_in_t  in_data,
  // result items
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pbc_pkg::pbc_out_t      out_data,
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [23:0]       cfg_wdata
);

  // Configuration registers
  logic [1:0]  op_r;
  logic [6:0]  mode_r;
  logic [23:0] fill_r;

  // Lookup stage: item fields held while the palette read completes
  logic               s1_v_r;
  logic               s1_v_nxt;
  pbc_pkg::pbc_in_t   s1_data_r;
  logic               s1_ready;
  logic               in_acc;
  logic               pix_acc;
  pbc_pkg::pbc_pal_req_t pal_req;
  logic [23:0]        pal_rdata;

  logic               idx0;
  logic               is_fill;
  logic               bypass;
  pbc_pkg::pbc_s1_t   s1_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= pbc_pkg::OP_COPY;
      mode_r <= pbc_pkg::MODE_RESET;
      fill_r <= 24'h000000;
    end else if (cfg_we) begin
      case (cfg_index)
        pbc_pkg::CFG_OPERATION:  op_r   <= cfg_wdata[1:0];
        pbc_pkg::CFG_BLEND_MODE: mode_r <= cfg_wdata[6:0];
        pbc_pkg::CFG_FILL_COLOR: fill_r <= cfg_wdata;
        default: ;  // no register there: drop the write
      endcase
    end
  end

  // Stall input only when the lookup stage is full and cannot advance
  assign in_stall = s1_v_r && !s1_ready;
  assign in_acc   = in_valid && !in_stall;
  assign pix_acc  = in_acc && (in_data.req_type == pbc_pkg::REQ_PIXEL);

  // Palette writes land at accept; pixels issue their read at accept.
  // A write accepted before a pixel is visible to it, one after is not,
  // so the single port needs no forwarding.
  always_comb begin
    pal_req.rd_en = pix_acc;
    pal_req.wr_en = in_acc && (in_data.req_type == pbc_pkg::REQ_PAL_WRITE);
    pal_req.index = in_data.src_index;
    pal_req.wdata = in_data.src_color;
  end

  pbc_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (pal_req),
    .rdata(pal_rdata)
  );

  // Only pixels enter the pipeline; palette writes give no result
  assign s1_v_nxt = pix_acc || (s1_v_r && !s1_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_data_r <= in_data;
    end
  end

  // Source selection. Index 0 is transparent in transparent copy (hold the
  // destination, no write) and passes the underlay in composite; both are
  // done by blending the base onto itself in opaque mode.
  assign idx0    = s1_data_r.src_indexed && (s1_data_r.src_index == 8'h00);
  assign is_fill = (op_r == pbc_pkg::OP_FILL);
  assign bypass  = !is_fill && idx0 &&
                   ((op_r == pbc_pkg::OP_TRANSP) || (op_r == pbc_pkg::OP_COMPOSITE));

  always_comb begin
    s1_out.dst  = s1_data_r.base_color;
    s1_out.mode = bypass ? pbc_pkg::MODE_OPAQUE : mode_r;
    s1_out.we   = !((op_r == pbc_pkg::OP_TRANSP) && idx0);
    if (is_fill) begin
      s1_out.src = fill_r;
    end else if (bypass) begin
      s1_out.src = s1_data_r.base_color;
    end else if (s1_data_r.src_indexed) begin
      s1_out.src = pal_rdata;
    end else begin
      s1_out.src = s1_data_r.src_color;
    end
  end

  pbc_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_v_r),
    .s1       (s1_out),
    .s1_ready (s1_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ src/pbc_checker.sv @@
// Port-level checker for the palette blend pixel compositor, bound to the top.
// Uses pbc_pkg types.
`default_nettype none

module pbc_port_props (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire pbc_pkg::pbc_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire pbc_pkg::pbc_out_t out_data
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // Input backs up only when every stage is full and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind palette_blend_pixel_compositor pbc_port_props u_pbc_port_props (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
